@@ rtl/lsrs_pkg.sv @@
`timescale 1ns / 1ps
package lsrs_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_HEARTBEAT     = 3'd0;
	localparam logic [2:0] REG_LOW_POWER     = 3'd1;
	localparam logic [2:0] REG_FAST_RETRY    = 3'd2;
	localparam logic [2:0] REG_SLOW_RETRY    = 3'd3;
	localparam logic [2:0] REG_CONN_TIMEOUT  = 3'd4;
	localparam logic [2:0] REG_FAST_LIMIT    = 3'd5;
	localparam logic [2:0] REG_TOTAL_LIMIT   = 3'd6;

	// input functions
	localparam logic [2:0] FN_TICK         = 3'd0;
	localparam logic [2:0] FN_CONNECTED    = 3'd1;
	localparam logic [2:0] FN_DISCONNECTED = 3'd2;
	localparam logic [2:0] FN_SUBSCRIBED   = 3'd3;
	localparam logic [2:0] FN_FALL         = 3'd4;
	localparam logic [2:0] FN_CLEARED      = 3'd5;
	localparam logic [2:0] FN_BATTERY      = 3'd6;
	localparam logic [2:0] FN_SHUTDOWN     = 3'd7;

	// actions
	localparam logic [3:0] ACT_NONE         = 4'd0;
	localparam logic [3:0] ACT_CONNECT      = 4'd1;
	localparam logic [3:0] ACT_DISCONNECT   = 4'd2;
	localparam logic [3:0] ACT_SUBSCRIBE    = 4'd3;
	localparam logic [3:0] ACT_FALL         = 4'd4;
	localparam logic [3:0] ACT_RESOLVED     = 4'd5;
	localparam logic [3:0] ACT_BATTERY      = 4'd6;
	localparam logic [3:0] ACT_REGISTRATION = 4'd7;
	localparam logic [3:0] ACT_HEARTBEAT    = 4'd8;

	// link states
	localparam logic [3:0] LS_INIT        = 4'd0;
	localparam logic [3:0] LS_NETOK       = 4'd1;
	localparam logic [3:0] LS_CONNECTING  = 4'd2;
	localparam logic [3:0] LS_CONNECTED   = 4'd3;
	localparam logic [3:0] LS_SUBSCRIBED  = 4'd4;
	localparam logic [3:0] LS_FAST        = 4'd5;
	localparam logic [3:0] LS_SLOW        = 4'd6;
	localparam logic [3:0] LS_SUBSCRIBING = 4'd7;
	localparam logic [3:0] LS_RESTART     = 4'd8;

	// scheduler intervals
	localparam logic [2:0] FALL_IVL     = 3'd4;
	localparam logic [3:0] RESOLVED_IVL = 4'd10;
	localparam logic [4:0] BATTERY_IVL  = 5'd20;
	localparam logic [2:0] REG_IVL      = 3'd4;
	localparam logic [1:0] GRACE        = 2'd2;
	localparam logic [6:0] LEVEL_MAX    = 7'd100;

	// x/10 == (x * 0xCCCD) >> 19 for every 16-bit x
	localparam logic [16:0] TENTH_MUL = 17'd52429;
	localparam int unsigned TENTH_SHIFT = 19;

	typedef struct packed {
		logic [15:0] heartbeat_ticks;
		logic [15:0] low_power_ticks;
		logic [15:0] heartbeat_fast;   // max(heartbeat_ticks / 10, 1)
		logic [15:0] low_power_fast;   // max(low_power_ticks / 10, 1)
		logic [7:0]  fast_retry_ticks;
		logic [7:0]  slow_retry_ticks;
		logic [7:0]  connect_timeout_ticks;
		logic [5:0]  fast_attempt_limit;
		logic [5:0]  total_attempt_limit;
	} lsrs_cfg_t;

	// speed-up interval of the heartbeat while an alarm is active
	function automatic logic [15:0] tenth_min1(input logic [15:0] x);
		logic [34:0] prod;
		logic [15:0] q;
		prod = {19'd0, x} * {18'd0, TENTH_MUL};
		q = prod[TENTH_SHIFT +: 16];
		return (q == 16'd0) ? 16'd1 : q;
	endfunction

endpackage

@@ rtl/lsrs_item_if.sv @@
`timescale 1ns / 1ps
interface lsrs_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic       net_up;
	logic       queue_ok;
	logic [6:0] level;

	modport source (output valid, output func, output net_up, output queue_ok, output level,
		input ready);
	modport sink (input valid, input func, input net_up, input queue_ok, input level,
		output ready);
endinterface

@@ rtl/lsrs_result_if.sv @@
`timescale 1ns / 1ps
interface lsrs_result_if;
	logic       valid;
	logic       ready;
	logic [3:0] action;
	logic [6:0] report_level;
	logic       alarm_flag;
	logic [3:0] link_state;

	modport source (output valid, output action, output report_level, output alarm_flag,
		output link_state, input ready);
	modport sink (input valid, input action, input report_level, input alarm_flag,
		input link_state, output ready);
endinterface

@@ rtl/link_supervisor_retry_scheduler_top.sv @@
`timescale 1ns / 1ps
// Link supervisor with publish retry scheduler.
//
// Channels: "item" carries one tick or link event per transaction (func,
// net_up, queue_ok, level); "result" returns exactly one transaction per
// item (action, report_level, alarm_flag, link_state). Both are valid/ready.
// The APB port holds the seven timing/limit registers at byte address 4*i;
// pready is tied high, so a write lands on the access cycle.
//
// Path: an accepted item goes into the input register, then through one pass
// of next-state logic into the result register.
// Throughput: one item per cycle while results are taken; the whole supervisor
// state updates in a single pass of compares and saturating counter increments.
//
// Reset: link in init, registration pending, all other counters and flags clear,
// registers at their defaults. No result is pending after reset.
// Stall: when result is not taken, the result register holds and the input
// register keeps its item; item.ready drops only when both are full.
// After a shutdown item the block keeps answering with action none and
// frozen outputs until the next reset.
module link_supervisor_retry_scheduler_top import lsrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	lsrs_item_if.sink         item,
	lsrs_result_if.source     result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	typedef struct packed {
		logic [3:0]  link_mode;
		logic [7:0]  connect_wait;
		logic [7:0]  retry_wait;
		logic [5:0]  attempt_count;
		logic        fall_pending;
		logic [2:0]  fall_wait;
		logic        resolved_pending;
		logic [3:0]  resolved_wait;
		logic        battery_pending;
		logic [4:0]  battery_wait;
		logic [6:0]  held_level;
		logic        registration_pending;
		logic [2:0]  registration_wait;
		logic [15:0] beat_count;
		logic        alarm_on;
		logic [1:0]  grace_left;
		logic        low_power;
		logic        dead;
	} sup_state_t;

	// state after reset: link in init, registration pending, rest clear
	localparam sup_state_t SUP_RESET = '{link_mode: LS_INIT, registration_pending: 1'b1,
		default: '0};

	lsrs_cfg_t  cfg;
	sup_state_t st_q, st_n;
	logic [3:0] act_n;

	// input register
	logic       valid_s1;
	logic [2:0] func_s1;
	logic       net_up_s1;
	logic       queue_ok_s1;
	logic [6:0] level_s1;

	// result register
	logic       res_valid_q;
	logic [3:0] action_q;

	logic advance;

	lsrs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// -------- handshake and staging --------
	assign advance    = valid_s1 & (~res_valid_q | result.ready);
	assign item.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			func_s1     <= item.func;
			net_up_s1   <= item.net_up;
			queue_ok_s1 <= item.queue_ok;
			level_s1    <= item.level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q <= act_n;
		end
	end

	// state doubles as the rest of the result payload: it only moves on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SUP_RESET;
		end else if (advance) begin
			st_q <= st_n;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.action       = action_q;
	assign result.report_level = st_q.held_level;
	assign result.alarm_flag   = st_q.alarm_on;
	assign result.link_state   = st_q.link_mode;

	// -------- next-state logic --------
	// Written as one ordered pass: a later step sees what an earlier step
	// did on the same tick (timeout -> backoff -> immediate retry).
	always_comb begin
		logic        done;
		logic [15:0] ivl;
		logic [15:0] ivl_fast;
		logic [7:0]  retry_ivl;

		st_n      = st_q;
		act_n     = ACT_NONE;
		done      = 1'b0;
		ivl       = st_q.low_power ? cfg.low_power_ticks : cfg.heartbeat_ticks;
		ivl_fast  = st_q.low_power ? cfg.low_power_fast : cfg.heartbeat_fast;
		retry_ivl = 8'd0;

		if (!st_q.dead) begin
			case (func_s1)
				FN_TICK: begin
					if (st_n.link_mode == LS_INIT && net_up_s1) begin
						st_n.link_mode = LS_NETOK;
					end
					if (st_n.link_mode == LS_NETOK) begin
						act_n          = ACT_CONNECT;
						st_n.link_mode = LS_CONNECTING;
					end
					if (st_n.link_mode == LS_CONNECTING) begin
						st_n.connect_wait = (st_n.connect_wait == 8'hFF) ? 8'hFF
							: st_n.connect_wait + 8'd1;
						if (st_n.connect_wait >= cfg.connect_timeout_ticks) begin
							act_n             = ACT_DISCONNECT;
							st_n.retry_wait   = 8'd0;
							st_n.connect_wait = 8'd0;
							if (st_n.attempt_count >= cfg.total_attempt_limit) begin
								st_n.link_mode = LS_RESTART;
							end else if (st_n.attempt_count >= cfg.fast_attempt_limit) begin
								st_n.link_mode = LS_SLOW;
							end else begin
								st_n.link_mode = LS_FAST;
							end
						end
					end
					if (st_n.link_mode == LS_CONNECTED) begin
						act_n          = ACT_SUBSCRIBE;
						st_n.link_mode = LS_SUBSCRIBING;
					end
					if (st_n.link_mode == LS_SUBSCRIBED) begin
						// fixed-priority publish scheduler, one attempt per tick
						act_n = ACT_NONE;
						if (st_n.fall_pending) begin
							st_n.fall_wait = (st_n.fall_wait == 3'd7) ? 3'd7
								: st_n.fall_wait + 3'd1;
							if (st_n.fall_wait >= FALL_IVL) begin
								st_n.fall_wait = 3'd0;
								done           = 1'b1;
								if (queue_ok_s1) begin
									st_n.fall_pending = 1'b0;
									act_n             = ACT_FALL;
								end
							end
						end
						if (!done && st_n.resolved_pending) begin
							st_n.resolved_wait = (st_n.resolved_wait == 4'd15) ? 4'd15
								: st_n.resolved_wait + 4'd1;
							if (st_n.resolved_wait >= RESOLVED_IVL) begin
								st_n.resolved_wait = 4'd0;
								done               = 1'b1;
								if (queue_ok_s1) begin
									st_n.resolved_pending = 1'b0;
									act_n                 = ACT_RESOLVED;
								end
							end
						end
						if (!done && st_n.battery_pending) begin
							st_n.battery_wait = (st_n.battery_wait == 5'd31) ? 5'd31
								: st_n.battery_wait + 5'd1;
							if (st_n.battery_wait >= BATTERY_IVL) begin
								st_n.battery_wait = 5'd0;
								done              = 1'b1;
								if (queue_ok_s1) begin
									st_n.battery_pending = 1'b0;
									act_n                = ACT_BATTERY;
								end
							end
						end
						if (!done && st_n.registration_pending) begin
							st_n.registration_wait = (st_n.registration_wait == 3'd7) ? 3'd7
								: st_n.registration_wait + 3'd1;
							if (st_n.registration_wait >= REG_IVL) begin
								st_n.registration_wait = 3'd0;
								done                   = 1'b1;
								if (queue_ok_s1) begin
									st_n.registration_pending = 1'b0;
									act_n                     = ACT_REGISTRATION;
								end
							end
						end
						if (!done) begin
							st_n.beat_count = (st_n.beat_count == 16'hFFFF) ? 16'hFFFF
								: st_n.beat_count + 16'd1;
							if (st_n.alarm_on && st_n.grace_left != 2'd0) begin
								st_n.grace_left = st_n.grace_left - 2'd1;
							end else if (st_n.alarm_on) begin
								if (st_n.beat_count >= ivl_fast) begin
									st_n.beat_count = 16'd0;
									act_n = queue_ok_s1 ? ACT_HEARTBEAT : ACT_NONE;
								end
							end else if (st_n.beat_count >= ivl) begin
								st_n.beat_count = 16'd0;
								act_n = queue_ok_s1 ? ACT_HEARTBEAT : ACT_NONE;
							end
						end
					end
					if (st_n.link_mode == LS_FAST || st_n.link_mode == LS_SLOW) begin
						retry_ivl = (st_n.link_mode == LS_FAST) ? cfg.fast_retry_ticks
							: cfg.slow_retry_ticks;
						st_n.retry_wait = (st_n.retry_wait == 8'hFF) ? 8'hFF
							: st_n.retry_wait + 8'd1;
						if (st_n.retry_wait >= retry_ivl) begin
							st_n.retry_wait = 8'd0;
							if (net_up_s1) begin
								st_n.attempt_count = (st_n.attempt_count == 6'd63) ? 6'd63
									: st_n.attempt_count + 6'd1;
								st_n.connect_wait = 8'd0;
								act_n             = ACT_CONNECT;
								st_n.link_mode    = LS_CONNECTING;
							end
						end
					end
				end
				FN_CONNECTED: begin
					st_n.attempt_count = 6'd0;
					st_n.retry_wait    = 8'd0;
					st_n.connect_wait  = 8'd0;
					st_n.link_mode     = LS_CONNECTED;
				end
				FN_DISCONNECTED: begin
					st_n.retry_wait   = 8'd0;
					st_n.connect_wait = 8'd0;
					if (st_q.attempt_count >= cfg.total_attempt_limit) begin
						st_n.link_mode = LS_RESTART;
					end else if (st_q.attempt_count >= cfg.fast_attempt_limit) begin
						st_n.link_mode = LS_SLOW;
					end else begin
						st_n.link_mode = LS_FAST;
					end
				end
				FN_SUBSCRIBED: begin
					st_n.link_mode            = LS_SUBSCRIBED;
					st_n.registration_pending = 1'b1;
					st_n.registration_wait    = REG_IVL;
					if (st_q.alarm_on) begin
						st_n.fall_pending = 1'b1;
						st_n.fall_wait    = FALL_IVL;
					end
				end
				FN_FALL: begin
					if (!st_q.alarm_on) begin
						st_n.alarm_on     = 1'b1;
						st_n.grace_left   = GRACE;
						st_n.fall_pending = 1'b1;
						st_n.fall_wait    = FALL_IVL;
					end
				end
				FN_CLEARED: begin
					st_n.alarm_on         = 1'b0;
					st_n.resolved_pending = 1'b1;
				end
				FN_BATTERY: begin
					if (!st_q.low_power) begin
						st_n.low_power  = 1'b1;
						st_n.beat_count = 16'd0;
					end
					st_n.held_level      = (level_s1 > LEVEL_MAX) ? LEVEL_MAX : level_s1;
					st_n.battery_pending = 1'b1;
					st_n.battery_wait    = BATTERY_IVL;
				end
				FN_SHUTDOWN: begin
					st_n.dead     = 1'b1;
					st_n.alarm_on = 1'b0;
					if (st_q.link_mode inside {LS_CONNECTED, LS_SUBSCRIBED,
							LS_SUBSCRIBING, LS_CONNECTING}) begin
						act_n = ACT_DISCONNECT;
					end
					st_n.link_mode = LS_RESTART;
				end
				default: ;
			endcase
		end
	end

	// -------- assertions --------
	// shutdown is permanent until reset
	a_dead_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.dead |=> st_q.dead)
		else $error("supervisor left shutdown without reset");

	// items after shutdown produce no action and leave the link in restart
	a_dead_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && st_q.dead) |=> (action_q == ACT_NONE && st_q.link_mode == LS_RESTART))
		else $error("action issued after shutdown");

	// publishes only come out of the subscribed state
	a_publish_subscribed: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && action_q >= ACT_FALL) |-> (st_q.link_mode == LS_SUBSCRIBED))
		else $error("publish action outside subscribed state");

	// every processed item lands in the result register
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("processed transaction has no result");

endmodule

@@ rtl/lsrs_cfg.sv @@
`timescale 1ns / 1ps
module lsrs_cfg import lsrs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output lsrs_cfg_t         cfg
);

	lsrs_cfg_t  cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	// the divided heartbeat intervals are captured with the write itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heartbeat_ticks       <= 16'd60;
			cfg_q.low_power_ticks       <= 16'd240;
			cfg_q.heartbeat_fast        <= 16'd6;
			cfg_q.low_power_fast        <= 16'd24;
			cfg_q.fast_retry_ticks      <= 8'd10;
			cfg_q.slow_retry_ticks      <= 8'd120;
			cfg_q.connect_timeout_ticks <= 8'd40;
			cfg_q.fast_attempt_limit    <= 6'd5;
			cfg_q.total_attempt_limit   <= 6'd32;
		end else if (wr_en) begin
			case (idx)
				REG_HEARTBEAT: begin
					cfg_q.heartbeat_ticks <= pwdata[15:0];
					cfg_q.heartbeat_fast  <= tenth_min1(pwdata[15:0]);
				end
				REG_LOW_POWER: begin
					cfg_q.low_power_ticks <= pwdata[15:0];
					cfg_q.low_power_fast  <= tenth_min1(pwdata[15:0]);
				end
				REG_FAST_RETRY:   cfg_q.fast_retry_ticks      <= pwdata[7:0];
				REG_SLOW_RETRY:   cfg_q.slow_retry_ticks      <= pwdata[7:0];
				REG_CONN_TIMEOUT: cfg_q.connect_timeout_ticks <= pwdata[7:0];
				REG_FAST_LIMIT:   cfg_q.fast_attempt_limit    <= pwdata[5:0];
				REG_TOTAL_LIMIT:  cfg_q.total_attempt_limit   <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_HEARTBEAT:    prdata = {16'd0, cfg_q.heartbeat_ticks};
			REG_LOW_POWER:    prdata = {16'd0, cfg_q.low_power_ticks};
			REG_FAST_RETRY:   prdata = {24'd0, cfg_q.fast_retry_ticks};
			REG_SLOW_RETRY:   prdata = {24'd0, cfg_q.slow_retry_ticks};
			REG_CONN_TIMEOUT: prdata = {24'd0, cfg_q.connect_timeout_ticks};
			REG_FAST_LIMIT:   prdata = {26'd0, cfg_q.fast_attempt_limit};
			REG_TOTAL_LIMIT:  prdata = {26'd0, cfg_q.total_attempt_limit};
			default:          prdata = '0;
		endcase
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import lsrs_pkg::*;

	// heartbeat interval divisor while an alarm is active
	localparam logic [15:0] BEAT_SPEEDUP = 16'd10;
	// cycles allowed after the last result before a register write or the verdict
	localparam int SETTLE_CYCLES = 6;
	// receiver hold-off used to back the block up into its input
	localparam int LONG_HOLD_CYCLES = 160;
	// global watchdog, far above the slowest legal run
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 190;

	// one result transaction as seen on the result channel
	typedef struct packed {
		logic [3:0] action;
		logic [6:0] level;
		logic       alarm;
		logic [3:0] link;
	} link_outcome_t;

	// receiver ready patterns
	typedef enum int {RX_OPEN, RX_SPOTTY, RX_THIRD, RX_SPARSE} rx_pattern_t;

	// Tracks the supervisor: own copy of the registers and state, and the
	// outcomes still owed by the block, oldest first.
	class supervisor_tracker;
		logic [15:0] beat_ivl;
		logic [15:0] low_power_ivl;
		logic [7:0]  fast_ivl;
		logic [7:0]  slow_ivl;
		logic [7:0]  connect_limit;
		logic [5:0]  fast_limit;
		logic [5:0]  total_limit;

		logic [3:0]  mode;
		logic [7:0]  connect_wait;
		logic [7:0]  retry_wait;
		logic [5:0]  attempts;
		logic        fall_pend;
		logic [2:0]  fall_wait;
		logic        res_pend;
		logic [3:0]  res_wait;
		logic        bat_pend;
		logic [4:0]  bat_wait;
		logic [6:0]  held_level;
		logic        reg_pend;
		logic [2:0]  reg_wait;
		logic [15:0] beats;
		logic        alarm;
		logic [1:0]  grace;
		logic        low_power;
		logic        dead;

		link_outcome_t outcomes[$];
		int errors;

		function new();
			beat_ivl = 16'd60;
			low_power_ivl = 16'd240;
			fast_ivl = 8'd10;
			slow_ivl = 8'd120;
			connect_limit = 8'd40;
			fast_limit = 6'd5;
			total_limit = 6'd32;
			mode = LS_INIT;
			connect_wait = '0;
			retry_wait = '0;
			attempts = '0;
			fall_pend = 1'b0;
			fall_wait = '0;
			res_pend = 1'b0;
			res_wait = '0;
			bat_pend = 1'b0;
			bat_wait = '0;
			held_level = '0;
			reg_pend = 1'b1;
			reg_wait = '0;
			beats = '0;
			alarm = 1'b0;
			grace = '0;
			low_power = 1'b0;
			dead = 1'b0;
			errors = 0;
		endfunction

		function void set_register(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_HEARTBEAT: beat_ivl = value[15:0];
				REG_LOW_POWER: low_power_ivl = value[15:0];
				REG_FAST_RETRY: fast_ivl = value[7:0];
				REG_SLOW_RETRY: slow_ivl = value[7:0];
				REG_CONN_TIMEOUT: connect_limit = value[7:0];
				REG_FAST_LIMIT: fast_limit = value[5:0];
				REG_TOTAL_LIMIT: total_limit = value[5:0];
				default: ;
			endcase
		endfunction

		function void enter_backoff();
			retry_wait = '0;
			connect_wait = '0;
			if (attempts >= total_limit)
				mode = LS_RESTART;
			else if (attempts >= fast_limit)
				mode = LS_SLOW;
			else
				mode = LS_FAST;
		endfunction

		// fixed-priority publish slot, at most one attempt per tick
		function logic [3:0] publish_pick(logic q);
			logic [15:0] ivl;
			logic [15:0] quick;
			if (fall_pend) begin
				if (fall_wait != 3'd7) fall_wait++;
				if (fall_wait >= FALL_IVL) begin
					fall_wait = '0;
					if (q) begin
						fall_pend = 1'b0;
						return ACT_FALL;
					end
					return ACT_NONE;
				end
			end
			if (res_pend) begin
				if (res_wait != 4'd15) res_wait++;
				if (res_wait >= RESOLVED_IVL) begin
					res_wait = '0;
					if (q) begin
						res_pend = 1'b0;
						return ACT_RESOLVED;
					end
					return ACT_NONE;
				end
			end
			if (bat_pend) begin
				if (bat_wait != 5'd31) bat_wait++;
				if (bat_wait >= BATTERY_IVL) begin
					bat_wait = '0;
					if (q) begin
						bat_pend = 1'b0;
						return ACT_BATTERY;
					end
					return ACT_NONE;
				end
			end
			if (reg_pend) begin
				if (reg_wait != 3'd7) reg_wait++;
				if (reg_wait >= REG_IVL) begin
					reg_wait = '0;
					if (q) begin
						reg_pend = 1'b0;
						return ACT_REGISTRATION;
					end
					return ACT_NONE;
				end
			end
			if (beats != 16'hFFFF) beats++;
			ivl = low_power ? low_power_ivl : beat_ivl;
			quick = ivl / BEAT_SPEEDUP;
			if (quick == 16'd0) quick = 16'd1;
			if (alarm && grace != 2'd0) begin
				grace--;
			end else if (alarm) begin
				if (beats >= quick) begin
					beats = '0;
					return q ? ACT_HEARTBEAT : ACT_NONE;
				end
			end else if (beats >= ivl) begin
				beats = '0;
				return q ? ACT_HEARTBEAT : ACT_NONE;
			end
			return ACT_NONE;
		endfunction

		// later stages override the action of earlier ones within a tick
		function logic [3:0] tick_step(logic n, logic q);
			logic [3:0] act;
			logic [7:0] ivl;
			act = ACT_NONE;
			if (mode == LS_INIT && n) mode = LS_NETOK;
			if (mode == LS_NETOK) begin
				act = ACT_CONNECT;
				mode = LS_CONNECTING;
			end
			if (mode == LS_CONNECTING) begin
				if (connect_wait != 8'hFF) connect_wait++;
				if (connect_wait >= connect_limit) begin
					act = ACT_DISCONNECT;
					enter_backoff();
				end
			end
			if (mode == LS_CONNECTED) begin
				act = ACT_SUBSCRIBE;
				mode = LS_SUBSCRIBING;
			end
			if (mode == LS_SUBSCRIBED) act = publish_pick(q);
			if (mode == LS_FAST || mode == LS_SLOW) begin
				ivl = (mode == LS_FAST) ? fast_ivl : slow_ivl;
				if (retry_wait != 8'hFF) retry_wait++;
				if (retry_wait >= ivl) begin
					retry_wait = '0;
					if (n) begin
						if (attempts != 6'h3F) attempts++;
						connect_wait = '0;
						act = ACT_CONNECT;
						mode = LS_CONNECTING;
					end
				end
			end
			return act;
		endfunction

		function void note_item(logic [2:0] f, logic n, logic q, logic [6:0] l);
			link_outcome_t o;
			logic [3:0] act;
			act = ACT_NONE;
			if (!dead) begin
				case (f)
					FN_TICK: act = tick_step(n, q);
					FN_CONNECTED: begin
						attempts = '0;
						retry_wait = '0;
						connect_wait = '0;
						mode = LS_CONNECTED;
					end
					FN_DISCONNECTED: enter_backoff();
					FN_SUBSCRIBED: begin
						mode = LS_SUBSCRIBED;
						reg_pend = 1'b1;
						reg_wait = REG_IVL;
						if (alarm) begin
							fall_pend = 1'b1;
							fall_wait = FALL_IVL;
						end
					end
					FN_FALL: begin
						if (!alarm) begin
							alarm = 1'b1;
							grace = GRACE;
							fall_pend = 1'b1;
							fall_wait = FALL_IVL;
						end
					end
					FN_CLEARED: begin
						alarm = 1'b0;
						res_pend = 1'b1;
					end
					FN_BATTERY: begin
						if (!low_power) begin
							low_power = 1'b1;
							beats = '0;
						end
						held_level = (l > LEVEL_MAX) ? LEVEL_MAX : l;
						bat_pend = 1'b1;
						bat_wait = BATTERY_IVL;
					end
					default: begin
						dead = 1'b1;
						alarm = 1'b0;
						if (mode == LS_CONNECTED || mode == LS_SUBSCRIBED ||
							mode == LS_SUBSCRIBING || mode == LS_CONNECTING)
							act = ACT_DISCONNECT;
						mode = LS_RESTART;
					end
				endcase
			end
			o.action = act;
			o.level = held_level;
			o.alarm = alarm;
			o.link = mode;
			outcomes.push_back(o);
		endfunction

		function void flag(string what, int want, int got);
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
		endfunction

		function void check_result(link_outcome_t got);
			link_outcome_t want;
			if (outcomes.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual action %0d link %0d",
					$time, got.action, got.link);
				return;
			end
			want = outcomes.pop_front();
			if (got.action != want.action)
				flag("action", int'(want.action), int'(got.action));
			if (got.level != want.level)
				flag("report_level", int'(want.level), int'(got.level));
			if (got.alarm != want.alarm)
				flag("alarm_flag", int'(want.alarm), int'(got.alarm));
			if (got.link != want.link)
				flag("link_state", int'(want.link), int'(got.link));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	lsrs_item_if item_bus();
	lsrs_result_if result_bus();

	supervisor_tracker tracker;

	// receiver control: the stimulus raises long_hold_req, the receiver
	// process picks it up and counts the hold-off itself
	bit long_hold_req;
	int hold_left;
	int pattern_left;
	int rx_phase;
	rx_pattern_t rx_pattern;
	int cycle_count;

	link_supervisor_retry_scheduler_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Every input of the block gets a known value at time zero.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_bus.valid = 1'b0;
		item_bus.func = FN_TICK;
		item_bus.net_up = 1'b0;
		item_bus.queue_ok = 1'b0;
		item_bus.level = '0;
		result_bus.ready = 1'b0;
		long_hold_req = 1'b0;
		hold_left = 0;
		pattern_left = 0;
		rx_phase = 0;
		rx_pattern = RX_OPEN;
		tracker = new();
	end

	// Result side: check every accepted transaction against the oldest
	// outcome owed. Values are read at the edge, before any update lands.
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			tracker.check_result('{result_bus.action, result_bus.report_level,
				result_bus.alarm_flag, result_bus.link_state});
	end

	// Receiver ready: a long hold-off on request, otherwise a random pattern
	// that is redrawn after a run of random length (open, spotty, every third, sparse).
	always @(posedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_bus.ready <= 1'b0;
		end else begin
			if (pattern_left == 0) begin
				rx_pattern = rx_pattern_t'($urandom_range(0, 3));
				pattern_left = $urandom_range(16, 96);
			end
			pattern_left--;
			rx_phase++;
			case (rx_pattern)
				RX_OPEN: result_bus.ready <= 1'b1;
				RX_SPOTTY: result_bus.ready <= ($urandom_range(0, 99) < 70);
				RX_THIRD: result_bus.ready <= (rx_phase % 3 == 0);
				default: result_bus.ready <= ($urandom_range(0, 99) < 25);
			endcase
		end
	end

	// Watchdog.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// APB write: setup cycle, access cycle; the register takes the value on
	// the edge where the access phase sees pready.
	task automatic write_register(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		tracker.set_register(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_settings(logic [15:0] hb, logic [15:0] lp, logic [7:0] fr,
		logic [7:0] sr, logic [7:0] ct, logic [5:0] fl, logic [5:0] tl);
		write_register(REG_HEARTBEAT, {16'd0, hb});
		write_register(REG_LOW_POWER, {16'd0, lp});
		write_register(REG_FAST_RETRY, {24'd0, fr});
		write_register(REG_SLOW_RETRY, {24'd0, sr});
		write_register(REG_CONN_TIMEOUT, {24'd0, ct});
		write_register(REG_FAST_LIMIT, {26'd0, fl});
		write_register(REG_TOTAL_LIMIT, {26'd0, tl});
		@(posedge clk);
	endtask

	// Offer one transaction and hold it until the block takes it; the tracker
	// learns of it on the accepting edge, so the next pick sees fresh state.
	task automatic send_item(logic [2:0] f, logic n, logic q, logic [6:0] l);
		item_bus.valid <= 1'b1;
		item_bus.func <= f;
		item_bus.net_up <= n;
		item_bus.queue_ok <= q;
		item_bus.level <= l;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		tracker.note_item(f, n, q, l);
	endtask

	// Stop sending and let every owed result drain before touching registers.
	task automatic quiesce();
		item_bus.valid <= 1'b0;
		while (tracker.outcomes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed link sequences driven by the tracked link state,
	// with a share of pure noise. Shutdown is kept out: it ends all behavior.
	task automatic choose_item(output logic [2:0] f, output logic n, output logic q,
		output logic [6:0] l);
		int roll;
		roll = $urandom_range(0, 99);
		f = FN_TICK;
		n = ($urandom_range(0, 9) != 0);
		q = ($urandom_range(0, 9) < 8);
		l = 7'($urandom_range(0, 127));
		if (roll < 8) begin
			f = 3'($urandom_range(0, 6));
			n = 1'($urandom_range(0, 1));
			q = 1'($urandom_range(0, 1));
		end else begin
			roll = $urandom_range(0, 99);
			case (tracker.mode)
				LS_CONNECTING: if (roll < 30) f = FN_CONNECTED;
				LS_SUBSCRIBING: if (roll < 50) f = FN_SUBSCRIBED;
				LS_SUBSCRIBED: begin
					if (roll < 4)
						f = FN_FALL;
					else if (roll < 8)
						f = FN_CLEARED;
					else if (roll < 11)
						f = FN_BATTERY;
					else if (roll < 13)
						f = FN_DISCONNECTED;
				end
				LS_RESTART: if (roll < 5) f = FN_CONNECTED;
				default: ;
			endcase
		end
	endtask

	// Random transactions in bursts of random length; gaps between bursts
	// are random, and about a quarter of the bursts run straight on.
	task automatic run_random(int count);
		int burst_left;
		int gap;
		logic [2:0] f;
		logic n;
		logic q;
		logic [6:0] l;
		burst_left = $urandom_range(1, 40);
		for (int i = 0; i < count; i++) begin
			choose_item(f, n, q, l);
			send_item(f, n, q, l);
			burst_left--;
			if (burst_left == 0 && i != count - 1) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap > 0) begin
					item_bus.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk: short intervals so the link sees init, connecting, fast backoff,
		// connected and subscribed, and the scheduler fires within a few transactions.
		apply_settings(16'd6, 16'd9, 8'd3, 8'd5, 8'd8, 6'd2, 6'd6);
		send_item(FN_TICK, 1'b0, 1'b1, 7'd0);            // no network, stay in init
		send_item(FN_TICK, 1'b1, 1'b1, 7'd0);            // connect issued
		send_item(FN_DISCONNECTED, 1'b1, 1'b1, 7'd0);    // into fast backoff
		send_item(FN_TICK, 1'b1, 1'b1, 7'd0);
		send_item(FN_TICK, 1'b0, 1'b1, 7'd0);
		send_item(FN_TICK, 1'b1, 1'b1, 7'd0);            // retry interval reached
		send_item(FN_CONNECTED, 1'b1, 1'b1, 7'd0);
		send_item(FN_TICK, 1'b1, 1'b1, 7'd0);            // subscribe issued
		send_item(FN_SUBSCRIBED, 1'b1, 1'b1, 7'd0);
		send_item(FN_TICK, 1'b1, 1'b0, 7'd0);            // registration rejected by queue
		send_item(FN_FALL, 1'b1, 1'b1, 7'd0);
		send_item(FN_TICK, 1'b1, 1'b1, 7'd0);            // fall alarm goes out first
		send_item(FN_FALL, 1'b1, 1'b1, 7'd0);            // repeated fall is ignored
		send_item(FN_CLEARED, 1'b1, 1'b1, 7'd0);
		send_item(FN_BATTERY, 1'b1, 1'b1, 7'd127);       // level saturates, low power on
		send_item(FN_BATTERY, 1'b1, 1'b1, 7'd100);
		send_item(FN_BATTERY, 1'b1, 1'b1, 7'd0);
		send_item(FN_TICK, 1'b0, 1'b1, 7'd85);
		send_item(FN_SUBSCRIBED, 1'b0, 1'b1, 7'd42);     // subscribed again
		send_item(FN_FALL, 1'b1, 1'b0, 7'd0);
		send_item(FN_TICK, 1'b1, 1'b0, 7'd0);
		send_item(FN_DISCONNECTED, 1'b0, 1'b0, 7'd0);
		quiesce();

		// Random phases, each under its own register setting.
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: apply_settings(16'd1, 16'd1, 8'd1, 8'd1, 8'd1, 6'd0, 6'd0);
				1: apply_settings(16'd7, 16'd12, 8'd2, 8'd4, 8'd6, 6'd3, 6'd8);
				3: apply_settings(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 6'h3F, 6'h3F);
				5: apply_settings(16'($urandom_range(1, 300)), 16'($urandom_range(1, 65535)),
					8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
					8'($urandom_range(1, 255)), 6'($urandom_range(0, 63)),
					6'($urandom_range(0, 63)));
				default: apply_settings(16'($urandom_range(1, 40)), 16'($urandom_range(1, 60)),
					8'($urandom_range(1, 6)), 8'($urandom_range(1, 12)),
					8'($urandom_range(1, 10)), 6'($urandom_range(0, 6)),
					6'($urandom_range(0, 12)));
			endcase
			// one phase starts with the receiver holding off while items keep
			// coming, so the block backs up into its input
			if (p == 2) long_hold_req = 1'b1;
			run_random(PHASE_ITEMS);
			quiesce();
		end

		// Shutdown last: after it the block must ignore everything.
		send_item(FN_SHUTDOWN, 1'b1, 1'b1, 7'd0);
		send_item(FN_FALL, 1'b1, 1'b1, 7'd0);
		send_item(FN_BATTERY, 1'b1, 1'b1, 7'd55);
		send_item(FN_TICK, 1'b1, 1'b1, 7'd0);
		quiesce();

		if (tracker.outcomes.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, tracker.outcomes.size());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ link_supervisor_retry_scheduler_top.f @@
rtl/lsrs_pkg.sv
rtl/lsrs_item_if.sv
rtl/lsrs_result_if.sv
rtl/lsrs_cfg.sv
rtl/link_supervisor_retry_scheduler_top.sv
tb/tb_top.sv
